/* hw/rtl/apq_pkg.sv */
// Shared widths, operation and status codes, and controller-datapath interface types.
package apq_pkg;

    localparam int FUNC_W   = 2;
    localparam int ITEM_W   = 16;
    localparam int PRIO_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Operation codes on the func field.
    localparam logic [FUNC_W-1:0] FUNC_PUSH    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Which result format the datapath builds when it loads the result registers.
    typedef enum logic [2:0] {
        R_PUSH,
        R_EXTRACT,
        R_EMPTY,
        R_LOOKUP,
        R_NONE
    } t_res_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      accept;
        logic      step;
        logic      find;
        logic      shift;
        logic      move_init;
        logic      push;
        logic      fill_dec;
        logic      res_load;
        t_res_kind res_kind;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic rd_more;
        logic vld;
        logic match;
    } t_dp_sts;

endpackage

/* hw/rtl/array_min_priority_queue_unit.sv */
// Top level of the unsorted-array minimum priority queue.
//
//  Channel    Handshake              Signals
//  ---------  ---------------------  --------------------------------------------------
//  command    start && !busy         i_func, i_item, i_prio
//  result     o_valid (one cycle)    o_item_out, o_prio_out, o_found, o_status,
//                                    o_count, o_is_empty
//
// A push or an unused function code loads its result in a single state after the command
// transfer, and so does an extract on an empty queue. A lookup walks the stored entries
// one per cycle and stops at the first match. An extract
// first scans all fill entries for the minimum, then moves every later entry down one
// place. Both walks are paced by the single read port of the entry RAM, which returns
// one entry per cycle.
// Reset is synchronous and active low; it clears the fill count and the control state,
// while the entry RAM keeps whatever it holds, since only entries below the fill count
// are ever read. The receiver cannot stall: each result is presented for exactly one
// cycle with o_valid, and busy falls in that same cycle so the next command may
// transfer right away.
module array_min_priority_queue_unit import apq_pkg::*; #(
    parameter int CAPACITY  = 64,
    parameter int ITEM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [ITEM_W-1:0]   i_item,
    input  logic [PRIO_W-1:0]   i_prio,
    output logic                o_valid,
    output logic [ITEM_W-1:0]   o_item_out,
    output logic [PRIO_W-1:0]   o_prio_out,
    output logic                o_found,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count,
    output logic                o_is_empty
);

    // Command and status bundles between the controller and the datapath.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // The controller decides which phase runs: a push, a lookup walk,
    // or the two-pass extract (minimum search, then compaction).
    apq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // The datapath owns the entry RAM, the fill count, the scan pointers, the
    // running minimum and the result registers.
    apq_dp #(
        .CAPACITY  (CAPACITY),
        .ITEM_BITS (ITEM_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_item     (i_item),
        .i_prio     (i_prio),
        .o_item_out (o_item_out),
        .o_prio_out (o_prio_out),
        .o_found    (o_found),
        .o_status   (o_status),
        .o_count    (o_count),
        .o_is_empty (o_is_empty)
    );

endmodule

/* hw/rtl/apq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module apq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/apq_dp.sv */
// Datapath: entry RAM, fill count, scan pointers, minimum tracking and result registers.
module apq_dp import apq_pkg::*; #(
    parameter int CAPACITY  = 64,
    parameter int ITEM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [ITEM_W-1:0]   i_item,
    input  logic [PRIO_W-1:0]   i_prio,
    output logic [ITEM_W-1:0]   o_item_out,
    output logic [PRIO_W-1:0]   o_prio_out,
    output logic                o_found,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count,
    output logic                o_is_empty
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int SW     = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;
    localparam int RAM_W  = SW + PRIO_W;
    localparam logic [ITEM_W-1:0]  ITEM_MASK = ITEM_W'((64'd1 << SW) - 64'd1);
    localparam logic [FILL_W-1:0]  FILL_MAX  = FILL_W'(CAPACITY);

    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FILL_W-1:0] r_rd_idx;
    logic [FILL_W-1:0] r_cmp_idx;
    logic              r_vld;
    logic              r_hit;
    logic [FILL_W-1:0] r_best_idx;
    logic [SW-1:0]     r_best_item;
    logic [PRIO_W-1:0] r_best_prio;
    logic [ITEM_W-1:0] r_item;
    logic [PRIO_W-1:0] r_prio;

    logic [ITEM_W-1:0]   r_res_item;
    logic [PRIO_W-1:0]   r_res_prio;
    logic                r_res_found;
    logic [STATUS_W-1:0] r_res_status;
    logic [COUNT_W-1:0]  r_res_count;
    logic                r_res_empty;

    logic              full;
    logic              rd_more;
    logic              match;
    logic              better;
    logic              push_do;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [RAM_W-1:0]  ram_wdata;
    logic [RAM_W-1:0]  ram_rdata;
    logic [SW-1:0]     rd_item;
    logic [PRIO_W-1:0] rd_prio;
    logic [FILL_W-1:0] shift_addr;

    assign full     = (r_fill == FILL_MAX);
    assign rd_more  = (r_rd_idx < r_fill);
    assign rd_item  = ram_rdata[RAM_W-1:PRIO_W];
    assign rd_prio  = ram_rdata[PRIO_W-1:0];
    assign match    = r_vld && (rd_item == r_item[SW-1:0]);
    assign better   = !r_hit || (rd_prio < r_best_prio);
    assign push_do  = i_cmd.push && !full;

    // During the shift each entry read from index j is written back at j - 1.
    assign shift_addr = r_cmp_idx - FILL_W'(1);
    assign ram_we     = push_do || (i_cmd.shift && r_vld);
    assign ram_waddr  = push_do ? r_fill[ADDR_W-1:0] : shift_addr[ADDR_W-1:0];
    assign ram_wdata  = push_do ? {r_item[SW-1:0], r_prio} : ram_rdata;

    always_comb begin
        n_fill = r_fill;
        if (push_do) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (i_cmd.fill_dec) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    apq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_rd_idx <= '0;
            r_vld    <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_cmd.accept) begin
                r_rd_idx <= '0;
                r_vld    <= 1'b0;
                r_hit    <= 1'b0;
            end else if (i_cmd.move_init) begin
                r_rd_idx <= r_best_idx + FILL_W'(1);
                r_vld    <= 1'b0;
            end else if (i_cmd.step) begin
                r_vld <= rd_more;
                if (rd_more) begin
                    r_rd_idx <= r_rd_idx + FILL_W'(1);
                end
                if (i_cmd.find && r_vld && better) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item & ITEM_MASK;
            r_prio <= i_prio;
        end
        if (i_cmd.step) begin
            r_cmp_idx <= r_rd_idx;
        end
        if (i_cmd.find && r_vld && better) begin
            r_best_idx  <= r_cmp_idx;
            r_best_item <= rd_item;
            r_best_prio <= rd_prio;
        end
        if (i_cmd.res_load) begin
            r_res_count <= COUNT_W'(n_fill);
            r_res_empty <= (n_fill == '0);
            unique case (i_cmd.res_kind)
                R_PUSH: begin
                    r_res_item   <= r_item;
                    r_res_prio   <= '0;
                    r_res_found  <= 1'b0;
                    r_res_status <= full ? ST_FULL : ST_OK;
                end
                R_EXTRACT: begin
                    r_res_item   <= ITEM_W'(r_best_item);
                    r_res_prio   <= r_best_prio;
                    r_res_found  <= 1'b1;
                    r_res_status <= ST_OK;
                end
                R_EMPTY: begin
                    r_res_item   <= r_item;
                    r_res_prio   <= '0;
                    r_res_found  <= 1'b0;
                    r_res_status <= ST_EMPTY;
                end
                R_LOOKUP: begin
                    r_res_item   <= r_item;
                    r_res_prio   <= match ? rd_prio : '0;
                    r_res_found  <= match;
                    r_res_status <= ST_OK;
                end
                default: begin
                    r_res_item   <= r_item;
                    r_res_prio   <= '0;
                    r_res_found  <= 1'b0;
                    r_res_status <= ST_OK;
                end
            endcase
        end
    end

    assign o_sts.empty   = (r_fill == '0);
    assign o_sts.rd_more = rd_more;
    assign o_sts.vld     = r_vld;
    assign o_sts.match   = match;

    assign o_item_out = r_res_item;
    assign o_prio_out = r_res_prio;
    assign o_found    = r_res_found;
    assign o_status   = r_res_status;
    assign o_count    = r_res_count;
    assign o_is_empty = r_res_empty;

endmodule

/* hw/rtl/apq_ctrl.sv */
// Controller state machine that sequences push, scan and shift operations.
module apq_ctrl import apq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [FUNC_W-1:0] i_func,
    input  t_dp_sts           i_sts,
    output t_dp_cmd           o_cmd,
    output logic              busy,
    output logic              o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_NOP,
        S_EMPTY,
        S_LOOK,
        S_FIND,
        S_MOVE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_done, n_done;
    logic   scan_over;

    // The scan is over once every read has been issued and the last one compared.
    assign scan_over = !i_sts.rd_more && !i_sts.vld;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_done  = 1'b0;
        o_cmd   = '0;
        o_cmd.res_kind = R_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_busy       = 1'b1;
                    unique case (i_func)
                        FUNC_PUSH:    n_state = S_PUSH;
                        FUNC_EXTRACT: n_state = i_sts.empty ? S_EMPTY : S_FIND;
                        FUNC_LOOKUP:  n_state = S_LOOK;
                        default:      n_state = S_NOP;
                    endcase
                end
            end
            S_PUSH: begin
                o_cmd.push     = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = R_PUSH;
            end
            S_NOP: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = R_NONE;
            end
            S_EMPTY: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = R_EMPTY;
            end
            S_LOOK: begin
                o_cmd.step = 1'b1;
                if (i_sts.match || scan_over) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = R_LOOKUP;
                end
            end
            S_FIND: begin
                if (scan_over) begin
                    o_cmd.move_init = 1'b1;
                    n_state         = S_MOVE;
                end else begin
                    o_cmd.step = 1'b1;
                    o_cmd.find = 1'b1;
                end
            end
            S_MOVE: begin
                if (scan_over) begin
                    o_cmd.fill_dec = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = R_EXTRACT;
                end else begin
                    o_cmd.step  = 1'b1;
                    o_cmd.shift = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
        if (o_cmd.res_load) begin
            n_state = S_IDLE;
            n_busy  = 1'b0;
            n_done  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_done;

endmodule
